// ----- rtl/core/bpfl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared widths, latencies and register indexes of the fragment lighting block.
// ----------------------------------------------------------------------------
package bpfl_pkg;

  localparam int COORD_WIDTH = 24;   // default coordinate width, Q8.16

  localparam int MAG_W  = 24;        // magnitude width fed to the squarer
  localparam int ROOT_W = MAG_W + 1; // integer square root width
  localparam int QUO_W  = 16;        // quotient bits of a unit component
  localparam int UNIT_W = 17;        // signed Q1.15 unit component

  // abs/shift, square, sum, one stage per root bit, one per quotient bit, sign
  localparam int NORM_LAT = 3 + ROOT_W + QUO_W + 1;

  localparam int COL_W = 48;
  localparam int CH_W  = 16;
  localparam int OUT_W = 17;

  localparam logic [15:0]      ONE_Q15 = 16'd32768;
  localparam logic [OUT_W-1:0] SAT_OUT = 17'd65536;

  typedef enum logic [2:0] {
    REG_DIFFUSE  = 3'd0,
    REG_SPECULAR = 3'd1,
    REG_EMISSIVE = 3'd2,
    REG_LIGHT    = 3'd3,
    REG_AMBIENT  = 3'd4,
    REG_LPOS_X   = 3'd5,
    REG_LPOS_Y   = 3'd6,
    REG_LPOS_Z   = 3'd7
  } cfg_reg_e;

endpackage

// ----- rtl/core/blinn_phong_fragment_lighting.sv -----
// ----------------------------------------------------------------------------
// blinn_phong_fragment_lighting
// One-light Blinn-Phong shading without shininess, fixed point, eye at origin.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, point_*, normal_* | request in
//  out     | out_valid_o/out_ready_i, red/green/blue  | result out
//  cfg     | cfg_valid_i/cfg_ready_o, index, data     | write in
//
//  One fragment per clock while the result is not held; the path runs through
//  the two normaliser pipelines in series (root and quotient, one bit a stage).
//  Reset zeroes the valid bits and config registers; cfg is always ready.
//  A stalled result holds the whole pipeline, nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module blinn_phong_fragment_lighting #(
  parameter int COORD_WIDTH = bpfl_pkg::COORD_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [2:0]                         cfg_index_i,
  input  logic [bpfl_pkg::COL_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  input  logic signed [COORD_WIDTH-1:0]      point_z_i,
  input  logic signed [COORD_WIDTH-1:0]      normal_x_i,
  input  logic signed [COORD_WIDTH-1:0]      normal_y_i,
  input  logic signed [COORD_WIDTH-1:0]      normal_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bpfl_pkg::OUT_W-1:0]         red_o,
  output logic [bpfl_pkg::OUT_W-1:0]         green_o,
  output logic [bpfl_pkg::OUT_W-1:0]         blue_o
);

  localparam int IW   = COORD_WIDTH + 1;
  localparam int UW   = bpfl_pkg::UNIT_W;
  localparam int HW   = UW + 1;
  localparam int PW   = 2 * UW;
  localparam int DW   = PW + 2;
  localparam int CW   = bpfl_pkg::CH_W;
  localparam int OW   = bpfl_pkg::OUT_W;
  localparam int NL   = bpfl_pkg::NORM_LAT;
  localparam int SUMW = OW + 2;
  localparam int LTW  = 3 * CW;

  // configuration registers
  logic [bpfl_pkg::COL_W-1:0] diffuse_q, specular_q, emissive_q, light_q, ambient_q;
  logic [2:0][COORD_WIDTH-1:0] lpos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diffuse_q  <= '0;
      specular_q <= '0;
      emissive_q <= '0;
      light_q    <= '0;
      ambient_q  <= '0;
      lpos_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (bpfl_pkg::cfg_reg_e'(cfg_index_i))
        bpfl_pkg::REG_DIFFUSE:  diffuse_q  <= cfg_data_i;
        bpfl_pkg::REG_SPECULAR: specular_q <= cfg_data_i;
        bpfl_pkg::REG_EMISSIVE: emissive_q <= cfg_data_i;
        bpfl_pkg::REG_LIGHT:    light_q    <= cfg_data_i;
        bpfl_pkg::REG_AMBIENT:  ambient_q  <= cfg_data_i;
        bpfl_pkg::REG_LPOS_X:   lpos_q[0]  <= cfg_data_i[COORD_WIDTH-1:0];
        bpfl_pkg::REG_LPOS_Y:   lpos_q[1]  <= cfg_data_i[COORD_WIDTH-1:0];
        bpfl_pkg::REG_LPOS_Z:   lpos_q[2]  <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the result register is held
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic [2:0][COORD_WIDTH-1:0] pt, nr;
  logic [2:0][IW-1:0]          lvec, nvec, vvec;

  assign pt = {point_z_i, point_y_i, point_x_i};
  assign nr = {normal_z_i, normal_y_i, normal_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvec[i] = {lpos_q[i][COORD_WIDTH-1], lpos_q[i]} - {pt[i][COORD_WIDTH-1], pt[i]};
      vvec[i] = IW'(0) - {pt[i][COORD_WIDTH-1], pt[i]};
      nvec[i] = {nr[i][COORD_WIDTH-1], nr[i]};
    end
  end

  logic               vl, vn, vv;
  logic [2:0][UW-1:0] ul, un, uv;

  bpfl_norm #(.IN_W(IW)) u_norm_l (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(lvec),
    .valid_o(vl), .unit_o(ul)
  );
  bpfl_norm #(.IN_W(IW)) u_norm_n (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(nvec),
    .valid_o(vn), .unit_o(un)
  );
  bpfl_norm #(.IN_W(IW)) u_norm_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(vvec),
    .valid_o(vv), .unit_o(uv)
  );

  // half vector
  logic [2:0][HW-1:0] hvec;
  logic               va, vh;
  logic [2:0][UW-1:0] uh;

  assign va = vl & vn & vv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hvec[i] = {ul[i][UW-1], ul[i]} + {uv[i][UW-1], uv[i]};
    end
  end

  bpfl_norm #(.IN_W(HW)) u_norm_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va), .vec_i(hvec),
    .valid_o(vh), .unit_o(uh)
  );

  // hold N and L alongside the half-vector normaliser
  logic [2:0][UW-1:0] dn_q [NL];
  logic [2:0][UW-1:0] dl_q [NL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q[0] <= un;
      dl_q[0] <= ul;
      for (int k = 1; k < NL; k++) begin
        dn_q[k] <= dn_q[k-1];
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  function automatic logic [CW-1:0] clamp_dot(input logic signed [DW-1:0] d);
    logic [DW-1:0] f;
    f = DW'(unsigned'(d)) >> 15;
    if (d <= 0) begin
      return '0;
    end else if (f > DW'(bpfl_pkg::ONE_Q15)) begin
      return bpfl_pkg::ONE_Q15;
    end else begin
      return f[CW-1:0];
    end
  endfunction

  // dot products
  logic                     v1_q, v2_q, v3_q, v4_q, vo_q;
  logic signed [2:0][PW-1:0] pd_q, ps_q;
  logic [CW-1:0]            fd2_q, fs2_q, fd3_q, fs3_q;
  logic [2:0][2*CW-1:0]     ml_q, sl_q;
  logic [2:0][OW-1:0]       dif_q, spe_q;
  logic [2:0][OW-1:0]       out_q;
  logic signed [DW-1:0]     sd, ss;
  logic [2:0][OW-1:0]       out_d;
  logic [SUMW-1:0]          tot;

  // the products are signed, so extend each with its sign
  always_comb begin
    sd = DW'($signed(pd_q[0])) + DW'($signed(pd_q[1])) + DW'($signed(pd_q[2]));
    ss = DW'($signed(ps_q[0])) + DW'($signed(ps_q[1])) + DW'($signed(ps_q[2]));
  end

  always_comb begin
    tot = '0;
    for (int c = 0; c < 3; c++) begin
      tot = SUMW'(dif_q[c]) + SUMW'(spe_q[c])
          + SUMW'(ambient_q[c*CW +: CW] >> 1) + SUMW'(emissive_q[c*CW +: CW] >> 1);
      out_d[c] = (tot > SUMW'(bpfl_pkg::SAT_OUT)) ? bpfl_pkg::SAT_OUT : tot[OW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= vh;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= $signed(dn_q[NL-1][i]) * $signed(dl_q[NL-1][i]);
        ps_q[i] <= $signed(dn_q[NL-1][i]) * $signed(uh[i]);
      end
      fd2_q <= clamp_dot(sd);
      fs2_q <= clamp_dot(ss);
      for (int c = 0; c < 3; c++) begin
        ml_q[c] <= diffuse_q[c*CW +: CW] * light_q[c*CW +: CW];
        sl_q[c] <= specular_q[c*CW +: CW] * light_q[c*CW +: CW];
      end
      fd3_q <= fd2_q;
      fs3_q <= fs2_q;
      // keep the full product width before dropping the fraction
      for (int c = 0; c < 3; c++) begin
        dif_q[c] <= OW'((LTW'(ml_q[c]) * LTW'(fd3_q)) >> 31);
        spe_q[c] <= OW'((LTW'(sl_q[c]) * LTW'(fs3_q)) >> 31);
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

endmodule

// ----- rtl/core/bpfl_norm.sv -----
// ----------------------------------------------------------------------------
// bpfl_norm
// Pipelined 3-vector normaliser: shift, square sum, bitwise square root and
// restoring division, giving signed Q1.15 unit components.
// ----------------------------------------------------------------------------
module bpfl_norm #(
  parameter int IN_W = bpfl_pkg::COORD_WIDTH + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [2:0][IN_W-1:0]                  vec_i,
  output logic                                  valid_o,
  output logic [2:0][bpfl_pkg::UNIT_W-1:0]      unit_o
);

  localparam int AW   = bpfl_pkg::MAG_W;
  localparam int MW   = (IN_W > AW) ? IN_W : AW;
  localparam int SHN  = MW - AW;
  localparam int SQW  = 2 * AW;
  localparam int RW   = bpfl_pkg::ROOT_W;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 3;
  localparam int QW   = bpfl_pkg::QUO_W;
  localparam int UW   = bpfl_pkg::UNIT_W;

  // stage 1: magnitudes, signs, common right shift
  logic [2:0][MW-1:0] mag;
  logic [MW-1:0]      m_or;
  logic [2:0][AW-1:0] a_d;
  logic [2:0]         neg_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][IN_W-1];
      mag[i]   = MW'(neg_d[i] ? IN_W'(~vec_i[i] + 1'b1) : vec_i[i]);
    end
    m_or = mag[0] | mag[1] | mag[2];
    for (int i = 0; i < 3; i++) a_d[i] = AW'(mag[i]);
    for (int s = SHN; s >= 0; s--) begin
      if (((m_or >> s) >> AW) == '0) begin
        for (int i = 0; i < 3; i++) a_d[i] = AW'(mag[i] >> s);
      end
    end
  end

  logic                v1_q, v2_q, v3_q;
  logic [2:0][AW-1:0]  a1_q, a2_q, a3_q;
  logic [2:0]          n1_q, n2_q, n3_q;
  logic [2:0][SQW-1:0] sq2_q;
  logic [RADW-1:0]     sum3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a_d;
      n1_q <= neg_d;
      for (int i = 0; i < 3; i++) sq2_q[i] <= a1_q[i] * a1_q[i];
      a2_q <= a1_q;
      n2_q <= n1_q;
      sum3_q <= RADW'(sq2_q[0]) + RADW'(sq2_q[1]) + RADW'(sq2_q[2]);
      a3_q <= a2_q;
      n3_q <= n2_q;
    end
  end

  // square root, one root bit per stage
  logic [RADW-1:0]    rad_q  [RW];
  logic [REMW-1:0]    rem_q  [RW];
  logic [RW-1:0]      root_q [RW];
  logic [2:0][AW-1:0] as_q   [RW];
  logic [2:0]         ns_q   [RW];
  logic [RW-1:0]      vs_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RADW-1:0]    rad_in;
    logic [REMW-1:0]    rem_in;
    logic [RW-1:0]      root_in;
    logic [2:0][AW-1:0] a_in;
    logic [2:0]         n_in;
    logic               v_in;
    logic [REMW-1:0]    rem2;
    logic [REMW-1:0]    trial;

    if (k == 0) begin : g_first
      assign rad_in  = sum3_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign a_in    = a3_q;
      assign n_in    = n3_q;
      assign v_in    = v3_q;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign a_in    = as_q[k-1];
      assign n_in    = ns_q[k-1];
      assign v_in    = vs_q[k-1];
    end

    always_comb begin
      rem2  = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
      trial = REMW'({root_in, 2'b01});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else if (en_i) begin
        vs_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= rad_in << 2;
        if (rem2 >= trial) begin
          rem_q[k]  <= rem2 - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem2;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
        as_q[k] <= a_in;
        ns_q[k] <= n_in;
      end
    end
  end

  // restoring division a * 2^15 / len, one quotient bit per stage
  logic [2:0][RW:0]   dx_q  [QW];
  logic [2:0][QW-1:0] dq_q  [QW];
  logic [RW-1:0]      dl_q  [QW];
  logic [2:0]         dn_q  [QW];
  logic [QW-1:0]      dz_q;
  logic [QW-1:0]      dv_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][RW:0]   x_in;
    logic [2:0][QW-1:0] q_in;
    logic [RW-1:0]      len_in;
    logic [2:0]         n_in;
    logic               z_in;
    logic               v_in;
    logic [2:0]         ge;
    logic [2:0][RW:0]   r;

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign x_in[i] = (RW + 1)'(as_q[RW-1][i]);
      end
      assign q_in   = '0;
      assign len_in = root_q[RW-1];
      assign n_in   = ns_q[RW-1];
      assign z_in   = (root_q[RW-1] == '0);
      assign v_in   = vs_q[RW-1];
    end else begin : g_next
      assign x_in   = dx_q[j-1];
      assign q_in   = dq_q[j-1];
      assign len_in = dl_q[j-1];
      assign n_in   = dn_q[j-1];
      assign z_in   = dz_q[j-1];
      assign v_in   = dv_q[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (x_in[i] >= {1'b0, len_in});
        r[i]  = ge[i] ? (x_in[i] - {1'b0, len_in}) : x_in[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dx_q[j][i] <= {r[i][RW-1:0], 1'b0};
          dq_q[j][i] <= {q_in[i][QW-2:0], ge[i]};
        end
        dl_q[j] <= len_in;
        dn_q[j] <= n_in;
        dz_q[j] <= z_in;
      end
    end
  end

  // sign and zero-length handling
  logic               vo_q;
  logic [2:0][UW-1:0] unit_q;
  logic [2:0][UW-1:0] unit_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz_q[QW-1]) begin
        unit_d[i] = '0;
      end else if (dn_q[QW-1][i]) begin
        unit_d[i] = UW'(~UW'(dq_q[QW-1][i]) + 1'b1);
      end else begin
        unit_d[i] = UW'(dq_q[QW-1][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) unit_q <= unit_d;
  end

  assign valid_o = vo_q;
  assign unit_o  = unit_q;

endmodule
